@@ sv/ptb_pkg.sv @@
`default_nettype none

package ptb_pkg;

  // Width of the handle fields on the ports
  localparam int unsigned QW = 16;

  // Time values are unsigned 24.8 fixed point
  localparam int unsigned TW = 32;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAN = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]    action;
    logic [TW-1:0] new_interval;
    logic          new_oneshot;
    logic [TW-1:0] lag_amount;
    logic [QW-1:0] query_handle;
  } in_item_t;

  typedef struct packed {
    logic [QW-1:0] given_handle;
    logic          fired;
    logic [1:0]    status;
  } out_item_t;

  // Per-slot verdict from the update unit to the sequencer
  typedef struct packed {
    logic hit;       // add found a free slot, or query matched
    logic fired;     // matched slot has reached its interval
    logic wr_en;     // write the entry back
    logic live_set;  // slot becomes live
    logic live_clr;  // slot is retired
  } slot_ctl_t;

endpackage

`default_nettype wire

@@ sv/ptb_in_if.sv @@
`default_nettype none

interface ptb_in_if;
  import ptb_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ sv/ptb_out_if.sv @@
`default_nettype none

interface ptb_out_if;
  import ptb_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ sv/ptb_slot_alu.sv @@
`default_nettype none

module ptb_slot_alu #(
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic [1:0]              act_i,
  input  wire logic                    live_i,
  input  wire logic                    rd_oneshot_i,
  input  wire logic [HANDLE_BITS-1:0]  rd_handle_i,
  input  wire logic [ptb_pkg::TW-1:0]  rd_elapsed_i,
  input  wire logic [ptb_pkg::TW-1:0]  rd_interval_i,
  input  wire logic [ptb_pkg::TW-1:0]  new_interval_i,
  input  wire logic                    new_oneshot_i,
  input  wire logic [ptb_pkg::TW-1:0]  lag_i,
  input  wire logic [ptb_pkg::QW-1:0]  query_handle_i,
  input  wire logic [HANDLE_BITS-1:0]  next_handle_i,
  output ptb_pkg::slot_ctl_t           ctl_o,
  output logic                         wr_oneshot_o,
  output logic [HANDLE_BITS-1:0]       wr_handle_o,
  output logic [ptb_pkg::TW-1:0]       wr_elapsed_o,
  output logic [ptb_pkg::TW-1:0]       wr_interval_o
);
  import ptb_pkg::*;

  localparam int unsigned CMPW = (HANDLE_BITS > QW) ? HANDLE_BITS : QW;

  logic          match;
  logic          expired;
  logic [TW:0]   sum;
  logic [TW-1:0] tick_el;
  logic [TW-1:0] diff;

  // Handle compare over the wider of the two widths
  assign match   = (CMPW'(rd_handle_i) == CMPW'(query_handle_i));
  assign expired = (rd_elapsed_i >= rd_interval_i);
  assign diff    = rd_elapsed_i - rd_interval_i;

  // Saturating tick add
  assign sum     = {1'b0, rd_elapsed_i} + {1'b0, lag_i};
  assign tick_el = sum[TW] ? '1 : sum[TW-1:0];

  always_comb begin
    ctl_o         = '0;
    wr_oneshot_o  = rd_oneshot_i;
    wr_handle_o   = rd_handle_i;
    wr_elapsed_o  = rd_elapsed_i;
    wr_interval_o = rd_interval_i;
    unique case (action_e'(act_i))
      ACT_ADD: begin
        // Claim the slot if it is free
        if (!live_i) begin
          ctl_o.hit      = 1'b1;
          ctl_o.wr_en    = 1'b1;
          ctl_o.live_set = 1'b1;
          wr_oneshot_o   = new_oneshot_i;
          wr_handle_o    = next_handle_i;
          wr_elapsed_o   = '0;
          wr_interval_o  = new_interval_i;
        end
      end
      ACT_TICK: begin
        if (live_i) begin
          ctl_o.wr_en  = 1'b1;
          wr_elapsed_o = tick_el;
        end
      end
      ACT_QUERY: begin
        if (live_i && match) begin
          ctl_o.hit   = 1'b1;
          ctl_o.fired = expired;
        end
      end
      ACT_CLEAN: begin
        // One-shot timers retire, periodic ones drop one interval
        if (live_i && expired) begin
          if (rd_oneshot_i) begin
            ctl_o.live_clr = 1'b1;
          end else begin
            ctl_o.wr_en  = 1'b1;
            wr_elapsed_o = diff;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/periodic_oneshot_timer_bank.sv @@
// A result is produced once the sweep over the slots ends: after the last slot, or on the first
// hit for an add or query. A new transaction is taken only once the previous result has been
// loaded into the output register. The sweep reads one slot entry per cycle from the single slot
// memory and writes any update back in the cycle after.
// Reset: asynchronous, active low; clears live bits, handle counter and control state.
`default_nettype none

module periodic_oneshot_timer_bank #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ptb_in_if.sink      in_i,
  ptb_out_if.source   out_o
);
  import ptb_pkg::*;

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned EW   = 1 + HANDLE_BITS + 2 * TW;
  localparam int unsigned CMPW = (HANDLE_BITS > QW) ? HANDLE_BITS : QW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  in_item_t               cmd_q;
  logic [CW-1:0]          iss_q, iss_d;
  logic                   p_vld_q, p_vld_d;
  logic [IW-1:0]          p_idx_q, p_idx_d;
  logic [SLOTS-1:0]       live_q;
  logic [HANDLE_BITS-1:0] next_q, next_d;
  out_item_t              res_q, res_d;
  out_item_t              out_data_q;
  logic                   out_vld_q;

  logic [EW-1:0]          mem_q [SLOTS];
  logic [EW-1:0]          rd_q;
  logic [EW-1:0]          wr_data;
  logic                   rd_en;
  logic [IW-1:0]          rd_addr;
  logic                   wr_en;

  logic                   in_fire;
  logic                   proc;
  logic                   last;
  logic                   scan_done;
  logic                   add_ok;
  logic                   out_free;
  logic                   out_ld;
  logic                   out_from_res;
  logic                   res_ld;
  logic [CMPW-1:0]        nh_ext;

  slot_ctl_t              ctl;
  logic                   wr_oneshot;
  logic [HANDLE_BITS-1:0] wr_handle;
  logic [TW-1:0]          wr_elapsed;
  logic [TW-1:0]          wr_interval;

  assign in_fire  = in_i.valid && in_i.ready;
  assign proc     = (state_q == S_SCAN) && p_vld_q;
  assign last     = (p_idx_q == IW'(SLOTS - 1));
  assign out_free = !out_vld_q || out_o.ready;
  assign nh_ext   = CMPW'(next_q);

  // Slot update unit
  ptb_slot_alu #(
    .HANDLE_BITS (HANDLE_BITS)
  ) u_alu (
    .act_i          (cmd_q.action),
    .live_i         (live_q[p_idx_q]),
    .rd_oneshot_i   (rd_q[EW-1]),
    .rd_handle_i    (rd_q[2*TW +: HANDLE_BITS]),
    .rd_elapsed_i   (rd_q[TW +: TW]),
    .rd_interval_i  (rd_q[TW-1:0]),
    .new_interval_i (cmd_q.new_interval),
    .new_oneshot_i  (cmd_q.new_oneshot),
    .lag_i          (cmd_q.lag_amount),
    .query_handle_i (cmd_q.query_handle),
    .next_handle_i  (next_q),
    .ctl_o          (ctl),
    .wr_oneshot_o   (wr_oneshot),
    .wr_handle_o    (wr_handle),
    .wr_elapsed_o   (wr_elapsed),
    .wr_interval_o  (wr_interval)
  );

  assign wr_en   = proc && ctl.wr_en;
  assign wr_data = {wr_oneshot, wr_handle, wr_elapsed, wr_interval};

  // Sweep ends on the last slot, or on the first hit for add and query
  assign scan_done = proc && (ctl.hit || last);
  assign add_ok    = scan_done && ctl.hit && (cmd_q.action == ACT_ADD);

  // Result of the finished sweep
  always_comb begin
    res_d = '0;
    res_d.status = ST_OK;
    if (cmd_q.action == ACT_ADD) begin
      if (ctl.hit) begin
        res_d.given_handle = nh_ext[QW-1:0];
      end else begin
        res_d.status = ST_FULL;
      end
    end else if (cmd_q.action == ACT_QUERY) begin
      if (ctl.hit) begin
        res_d.fired = ctl.fired;
      end else begin
        res_d.status = ST_UNKNOWN;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    iss_d        = iss_q;
    p_vld_d      = p_vld_q;
    p_idx_d      = p_idx_q;
    next_d       = next_q;
    rd_en        = 1'b0;
    rd_addr      = iss_q[IW-1:0];
    out_ld       = 1'b0;
    out_from_res = 1'b0;
    res_ld       = 1'b0;
    in_i.ready   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = S_SCAN;
          rd_en   = 1'b1;
          rd_addr = '0;
          iss_d   = CW'(1);
          p_vld_d = 1'b1;
          p_idx_d = '0;
        end
      end
      S_SCAN: begin
        // Read ahead one slot while the previous one is updated
        if (iss_q != CW'(SLOTS)) begin
          rd_en   = 1'b1;
          iss_d   = iss_q + CW'(1);
          p_vld_d = 1'b1;
          p_idx_d = iss_q[IW-1:0];
        end else begin
          p_vld_d = 1'b0;
        end
        if (scan_done) begin
          if (add_ok) begin
            next_d = next_q + HANDLE_BITS'(1);
          end
          if (out_free) begin
            out_ld  = 1'b1;
            state_d = S_IDLE;
          end else begin
            res_ld  = 1'b1;
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_ld       = 1'b1;
          out_from_res = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      next_q    <= '0;
      live_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      p_vld_q <= p_vld_d;
      p_idx_q <= p_idx_d;
      next_q  <= next_d;
      if (proc && ctl.live_set) begin
        live_q[p_idx_q] <= 1'b1;
      end else if (proc && ctl.live_clr) begin
        live_q[p_idx_q] <= 1'b0;
      end
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_i.data;
    end
    if (res_ld) begin
      res_q <= res_d;
    end
    if (out_ld) begin
      out_data_q <= out_from_res ? res_q : res_d;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[p_idx_q] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_data_q;

  // Write-back never lands on the slot being read in the same cycle
  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != p_idx_q))
    else $error("slot memory read and write collide");

  // A successful add advances the handle counter by one
  a_handle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    add_ok |=> (next_q == $past(next_q) + HANDLE_BITS'(1)))
    else $error("handle counter did not advance");

  // Output register is only loaded when it is empty or being drained
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!out_vld_q || out_o.ready))
    else $error("pending result overwritten");

  // An add only claims a slot that was free
  a_claim_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && ctl.live_set) |-> !live_q[p_idx_q])
    else $error("add claimed a live slot");

endmodule

`default_nettype wire

@@ tb/timer_bank_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the timer table and checks every
// result against the oldest outstanding prediction.
module timer_bank_checker
  import ptb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptb_in_if         in_mon,
  ptb_out_if        out_mon,
  output int        mismatch_count_o,
  output int        pending_o
);

  localparam int unsigned NSLOT = 16;

  // Shadow timer table
  logic          live_m   [NSLOT];
  logic          single_m [NSLOT];
  logic [QW-1:0] id_m     [NSLOT];
  logic [TW-1:0] age_m    [NSLOT];
  logic [TW-1:0] period_m [NSLOT];
  logic [QW-1:0] handle_ctr_m;

  out_item_t awaited_results [$];
  out_item_t oldest;
  int        errors = 0;
  int        slot;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Applies one transaction to the shadow table and returns the result it should give
  function automatic out_item_t advance_timer_table(input in_item_t item);
    out_item_t   res;
    logic        done;
    logic [TW:0] sum;
    int          k;
    res  = '0;
    done = 1'b0;
    case (action_e'(item.action))
      ACT_ADD: begin
        // lowest free slot wins; counter only moves on success
        for (k = 0; k < NSLOT; k++) begin
          if (!done && !live_m[k]) begin
            live_m[k]        = 1'b1;
            single_m[k]      = item.new_oneshot;
            id_m[k]          = handle_ctr_m;
            age_m[k]         = '0;
            period_m[k]      = item.new_interval;
            res.given_handle = handle_ctr_m;
            handle_ctr_m     = handle_ctr_m + 1'b1;
            done             = 1'b1;
          end
        end
        if (!done) res.status = ST_FULL;
      end
      ACT_TICK: begin
        // saturating add on every live timer
        for (k = 0; k < NSLOT; k++) begin
          if (live_m[k]) begin
            sum      = {1'b0, age_m[k]} + {1'b0, item.lag_amount};
            age_m[k] = sum[TW] ? '1 : sum[TW-1:0];
          end
        end
      end
      ACT_QUERY: begin
        // first matching live slot answers
        for (k = 0; k < NSLOT; k++) begin
          if (!done && live_m[k] && id_m[k] == item.query_handle) begin
            res.fired = (age_m[k] >= period_m[k]);
            done      = 1'b1;
          end
        end
        if (!done) res.status = ST_UNKNOWN;
      end
      default: begin
        // clean: retire expired one-shots, rewind expired periodics once
        for (k = 0; k < NSLOT; k++) begin
          if (live_m[k] && age_m[k] >= period_m[k]) begin
            if (single_m[k]) live_m[k] = 1'b0;
            else age_m[k] = age_m[k] - period_m[k];
          end
        end
      end
    endcase
    return res;
  endfunction

  // Compare results first, then predict from any new transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (slot = 0; slot < NSLOT; slot++) begin
        live_m[slot]   = 1'b0;
        single_m[slot] = 1'b0;
        id_m[slot]     = '0;
        age_m[slot]    = '0;
        period_m[slot] = '0;
      end
      handle_ctr_m = '0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with none outstanding, given_handle",
                          32'(out_mon.data.given_handle), 32'd0);
        end else begin
          oldest = awaited_results.pop_front();
          if (out_mon.data.given_handle !== oldest.given_handle)
            report_mismatch("given_handle", 32'(out_mon.data.given_handle),
                            32'(oldest.given_handle));
          if (out_mon.data.fired !== oldest.fired)
            report_mismatch("fired", 32'(out_mon.data.fired), 32'(oldest.fired));
          if (out_mon.data.status !== oldest.status)
            report_mismatch("status", 32'(out_mon.data.status), 32'(oldest.status));
        end
      end
      if (in_mon.valid && in_mon.ready)
        awaited_results.push_back(advance_timer_table(in_mon.data));
    end
    mismatch_count_o <= errors;
    pending_o        <= awaited_results.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import ptb_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_OPS   = 1650;
  localparam int unsigned CALM_TAIL    = 250;
  localparam int unsigned SWEEP_ROUNDS = 4;
  localparam int unsigned FREE_SLOTS   = 14;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          sink_ready    = 1'b0;
  logic          idle_on       = 1'b0;
  int unsigned   hold_left     = 0;
  int unsigned   quiet_cycles  = 0;
  logic [QW-1:0] newest_handle = '0;
  int            mismatches;
  int            pending_results;

  ptb_in_if  in_bus ();
  ptb_out_if out_bus ();

  assign out_bus.ready = sink_ready;

  periodic_oneshot_timer_bank u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  timer_bank_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_bus),
    .out_mon          (out_bus),
    .mismatch_count_o (mismatches),
    .pending_o        (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side back-pressure: random bursts of stalled cycles
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      sink_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_ready <= 1'b0;
      hold_left  <= $urandom_range(0, 11);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Remember the latest handle handed out so queries can aim at live timers
  always @(posedge clk_i) begin
    if (out_bus.valid && out_bus.ready && out_bus.data.status == ST_OK &&
        out_bus.data.given_handle != '0)
      newest_handle <= out_bus.data.given_handle;
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One command transaction; fields the action ignores carry noise
  task automatic push_item(input action_e act, input logic [TW-1:0] arg,
                           input logic flag, input logic [QW-1:0] qh);
    in_item_t item;
    item.action       = act;
    item.new_interval = (act == ACT_ADD) ? arg : $urandom;
    item.new_oneshot  = (act == ACT_ADD) ? flag : 1'($urandom);
    item.lag_amount   = (act == ACT_TICK) ? arg : $urandom;
    item.query_handle = (act == ACT_QUERY) ? qh : QW'($urandom);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= item;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned   pick;
    int unsigned   shape;
    int unsigned   n;
    logic [TW-1:0] val;
    logic [QW-1:0] qh;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni  <= 1'b1;
    idle_on <= 1'b1;
    @(negedge clk_i);

    // Directed: zero and maximum intervals, saturation, unknown handles
    push_item(ACT_ADD, '0, 1'b1, '0);           // h0 zero one-shot
    push_item(ACT_ADD, '1, 1'b0, '0);           // h1 max periodic
    push_item(ACT_ADD, '0, 1'b0, '0);           // h2 zero periodic
    push_item(ACT_QUERY, '0, 1'b0, 16'd0);      // fired at once
    push_item(ACT_QUERY, '0, 1'b0, 16'd1);      // not yet
    push_item(ACT_TICK, '1, 1'b0, '0);
    push_item(ACT_TICK, 32'd1, 1'b0, '0);       // elapsed overflows, clamps
    push_item(ACT_QUERY, '0, 1'b0, 16'd1);
    push_item(ACT_CLEAN, '0, 1'b0, '0);         // h0 retired, h1 rewound
    push_item(ACT_QUERY, '0, 1'b0, 16'd0);      // gone
    push_item(ACT_QUERY, '0, 1'b0, 16'd2);      // zero periodic still fired
    push_item(ACT_QUERY, '0, 1'b0, 16'hFFFF);

    // Fill and empty the table a few times while h1 and h2 stay live
    idle_on <= 1'b0;
    for (n = 0; n < SWEEP_ROUNDS; n++) begin
      repeat (FREE_SLOTS) push_item(ACT_ADD, '0, 1'b1, '0);
      if (n == 0) push_item(ACT_ADD, $urandom, 1'($urandom), '0);   // table full
      push_item(ACT_CLEAN, '0, 1'b0, '0);
    end

    // Fresh timers beside the long-lived h1 and h2
    push_item(ACT_ADD, '0, 1'b1, '0);
    push_item(ACT_ADD, '1, 1'b1, '0);
    push_item(ACT_QUERY, '0, 1'b0, 16'd1);
    push_item(ACT_QUERY, '0, 1'b0, 16'd2);
    push_item(ACT_CLEAN, '0, 1'b0, '0);
    push_item(ACT_QUERY, '0, 1'b0, 16'd1);

    // Random traffic, mostly small times, mostly one-shot so slots recycle
    for (n = 0; n < RANDOM_OPS; n++) begin
      idle_on <= (n < RANDOM_OPS - CALM_TAIL);
      pick  = $urandom_range(0, 99);
      shape = $urandom_range(0, 19);
      val   = (shape == 0) ? '0 : (shape == 1) ? '1 :
              (shape < 4) ? $urandom : $urandom_range(1, 'h4000);
      if (pick < 30) begin
        push_item(ACT_ADD, val, $urandom_range(0, 49) != 0, '0);
      end else if (pick < 50) begin
        push_item(ACT_TICK, val, 1'b0, '0);
      end else if (pick < 85) begin
        qh = (shape < 3) ? QW'($urandom) : newest_handle - QW'($urandom_range(0, 15));
        push_item(ACT_QUERY, '0, 1'b0, qh);
      end else begin
        push_item(ACT_CLEAN, '0, 1'b0, '0);
      end
    end

    // Drain and verdict
    in_bus.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ptb_pkg.sv
sv/ptb_in_if.sv
sv/ptb_out_if.sv
sv/ptb_slot_alu.sv
sv/periodic_oneshot_timer_bank.sv
tb/timer_bank_checker.sv
tb/tb_top.sv
